/* hw/rtl/amtm_pkg.sv */
// shared constants, register codes and helper functions of the am tone modulator
package amtm_pkg;

    // default sizes
    localparam int PHASE_BITS_DEF = 32;
    localparam int TABLE_BITS_DEF = 10;
    localparam int QUEUE_DEPTH    = 4;

    // field and register widths
    localparam int STEP_W     = 32;
    localparam int AMP_W      = 16;
    localparam int COUNT_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int SAMPLE_W   = 18;
    localparam int MSG_W      = 16;
    localparam int ENTRY_W    = 15;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd2;

    // register reset values
    localparam logic [AMP_W-1:0]   AMP_RESET   = 16'd4096;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 24'd1024;

    // arithmetic constants
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX   = 18'sh1FFFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN   = 18'sh20000;
    localparam logic signed [MSG_W:0]      MSG_GAIN  = 17'sd19661;
    localparam logic signed [MSG_W:0]      MSG_LIMIT = 17'sd19661;
    localparam logic signed [SAMPLE_W-1:0] ONE_Q15   = 18'sd32768;
    localparam logic [32:0]                DIV7_MAGIC = 33'h124924925;
    localparam int                         DIV7_SHIFT = 35;

    // one quarter-wave entry: taylor series of sin in q30, scaled to unsigned q0.15
    function automatic logic [ENTRY_W-1:0] f_sine_entry(input int unsigned k,
                                                        input int unsigned tb);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned t;
        x    = (64'd1686629713 * 64'(2 * k + 1)) >> (tb + 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 7; n++) begin
            t = (term * x2) >> 30;
            case (n)
                1:       term = t / 6;
                2:       term = t / 20;
                3:       term = t / 42;
                4:       term = t / 72;
                5:       term = t / 110;
                6:       term = t / 156;
                default: term = t / 210;
            endcase
            if ((n & 1) != 0) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        return ENTRY_W'((sum * 64'd32767 + (64'd1 << 29)) >> 30);
    endfunction

    // clamp to the 18-bit signed output range
    function automatic logic signed [SAMPLE_W-1:0] f_sat18(input logic signed [39:0] v);
        if (v > 40'(SAT_MAX)) begin
            return SAT_MAX;
        end else if (v < 40'(SAT_MIN)) begin
            return SAT_MIN;
        end
        return SAMPLE_W'(v);
    endfunction

endpackage

/* hw/rtl/amtm_if.sv */
// tick and sample channel interfaces of the am tone modulator

interface amtm_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface amtm_sample_if import amtm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] carrier_sample;
    logic signed [MSG_W-1:0]    message_sample;
    logic signed [SAMPLE_W-1:0] modulated_sample;
    logic                       last;

    modport source (output valid, output carrier_sample, output message_sample,
                    output modulated_sample, output last, input ready);
    modport sink   (input valid, input carrier_sample, input message_sample,
                    input modulated_sample, input last, output ready);
endinterface

/* hw/rtl/amtm_queue.sv */
// short fifo between the phase front end and the sample back end
module amtm_queue import amtm_pkg::*; #(
    parameter int WIDTH = 2 * (TABLE_BITS_DEF + 2) + 1,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    // status
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    // pointer and count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_count == '0))
        else $error("queue popped while empty");

endmodule

/* hw/rtl/amtm_front.sv */
// front end: takes tick beats, steps the phase accumulators and the run index
module amtm_front import amtm_pkg::*; #(
    parameter int PHASE_BITS = PHASE_BITS_DEF,
    parameter int TABLE_BITS = TABLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_restart,
    output logic                  o_ready,
    input  logic [PHASE_BITS-1:0] i_cstep,
    input  logic [PHASE_BITS-1:0] i_mstep,
    input  logic [COUNT_W-1:0]    i_sample_count,
    output logic                  o_push,
    output logic [2*(TABLE_BITS+2):0] o_job,
    input  logic                  i_full
);

    localparam int AW = TABLE_BITS + 2;
    localparam logic [PHASE_BITS-1:0] QUARTER = {2'b01, {(PHASE_BITS - 2){1'b0}}};

    logic [PHASE_BITS-1:0] r_cphase, n_cphase;
    logic [PHASE_BITS-1:0] r_mphase, n_mphase;
    logic [COUNT_W-1:0]    r_idx, n_idx;
    logic [PHASE_BITS-1:0] w_cph;
    logic [PHASE_BITS-1:0] w_mph;
    logic [PHASE_BITS-1:0] w_mcos;
    logic [COUNT_W-1:0]    w_idx;
    logic [COUNT_W-1:0]    w_idx_inc;
    logic                  w_last;
    logic                  w_accept;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;
    assign o_push   = w_accept;

    // restart takes effect before this sample
    assign w_cph     = i_restart ? '0 : r_cphase;
    assign w_mph     = i_restart ? '0 : r_mphase;
    assign w_idx     = i_restart ? '0 : r_idx;
    assign w_idx_inc = w_idx + 1'b1;
    assign w_last    = (w_idx_inc == i_sample_count);
    assign w_mcos    = w_mph + QUARTER;

    // job: carrier table address, cosine table address, last flag
    assign o_job = {w_cph[PHASE_BITS-1 -: AW], w_mcos[PHASE_BITS-1 -: AW], w_last};

    // accumulator advance, back to zero after the last sample of a run
    always_comb begin
        n_cphase = r_cphase;
        n_mphase = r_mphase;
        n_idx    = r_idx;
        if (w_accept) begin
            if (w_last) begin
                n_cphase = '0;
                n_mphase = '0;
                n_idx    = '0;
            end else begin
                n_cphase = w_cph + i_cstep;
                n_mphase = w_mph + i_mstep;
                n_idx    = w_idx_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cphase <= '0;
            r_mphase <= '0;
            r_idx    <= '0;
        end else begin
            r_cphase <= n_cphase;
            r_mphase <= n_mphase;
            r_idx    <= n_idx;
        end
    end

    // a run ends with all accumulators back at zero
    a_run_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |=> (r_cphase == '0 && r_mphase == '0 && r_idx == '0))
        else $error("accumulators not cleared after last sample");

endmodule

/* hw/rtl/amtm_back.sv */
// back end: table lookup, gain multiplies, rounding, saturation, output register
module amtm_back import amtm_pkg::*; #(
    parameter int TABLE_BITS = TABLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  logic [2*(TABLE_BITS+2):0]  i_q_data,
    output logic                       o_pop,
    input  logic [AMP_W-1:0]           i_amplitude,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SAMPLE_W-1:0] o_carrier,
    output logic signed [MSG_W-1:0]    o_message,
    output logic signed [SAMPLE_W-1:0] o_modulated,
    output logic                       o_last
);

    localparam int AW       = TABLE_BITS + 2;
    localparam int TBL_SIZE = 1 << TABLE_BITS;

    typedef logic [ENTRY_W-1:0] t_rom [TBL_SIZE];

    function automatic t_rom f_build_rom();
        t_rom rom;
        for (int k = 0; k < TBL_SIZE; k++) begin
            rom[k] = f_sine_entry(k, TABLE_BITS);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = f_build_rom();

    logic                  w_en;
    logic [AW-1:0]         w_cadr;
    logic [AW-1:0]         w_madr;
    logic [TABLE_BITS-1:0] w_cidx;
    logic [TABLE_BITS-1:0] w_midx;

    // stage 1: table read
    logic               r1_v;
    logic [ENTRY_W-1:0] r1_cval, r1_mval;
    logic               r1_cneg, r1_mneg, r1_last;
    // stage 2: gain products
    logic                     r2_v;
    logic signed [33:0]       r2_pc, r2_pm;
    logic                     r2_last;
    logic signed [MSG_W:0]    w_cs, w_ms;
    logic signed [AMP_W:0]    w_amp;
    // stage 3: rounded carrier and message
    logic                       r3_v;
    logic signed [SAMPLE_W-1:0] r3_car;
    logic signed [MSG_W-1:0]    r3_msg;
    logic                       r3_last;
    // stage 4: modulation product
    logic                       r4_v;
    logic signed [35:0]         r4_prod;
    logic signed [SAMPLE_W-1:0] r4_car;
    logic signed [MSG_W-1:0]    r4_msg;
    logic                       r4_last;
    logic signed [SAMPLE_W-1:0] w_gain;
    // output register
    logic r_out_valid;

    // whole pipe moves when the output register is free or being taken
    assign w_en    = !r_out_valid || i_ready;
    assign o_pop   = w_en && i_q_valid;
    assign o_valid = r_out_valid;

    // quadrant folding: odd quadrants read the table backwards
    assign w_cadr = i_q_data[2*AW -: AW];
    assign w_madr = i_q_data[AW:1];
    assign w_cidx = w_cadr[AW-2] ? ~w_cadr[TABLE_BITS-1:0] : w_cadr[TABLE_BITS-1:0];
    assign w_midx = w_madr[AW-2] ? ~w_madr[TABLE_BITS-1:0] : w_madr[TABLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_cval <= SINE_ROM[w_cidx];
            r1_mval <= SINE_ROM[w_midx];
            r1_cneg <= w_cadr[AW-1];
            r1_mneg <= w_madr[AW-1];
            r1_last <= i_q_data[0];
        end
    end

    // signed table values and gain multiplies
    assign w_cs  = r1_cneg ? -$signed({2'b00, r1_cval}) : $signed({2'b00, r1_cval});
    assign w_ms  = r1_mneg ? -$signed({2'b00, r1_mval}) : $signed({2'b00, r1_mval});
    assign w_amp = $signed({1'b0, i_amplitude});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_pc   <= w_amp * w_cs;
            r2_pm   <= MSG_GAIN * w_ms;
            r2_last <= r1_last;
        end
    end

    // round half up by 15 bits, clamp the carrier
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_car  <= f_sat18(40'((r2_pc + 34'sd16384) >>> 15));
            r3_msg  <= MSG_W'((r2_pm + 34'sd16384) >>> 15);
            r3_last <= r2_last;
        end
    end

    // (1 + message) times carrier
    assign w_gain = ONE_Q15 + SAMPLE_W'(r3_msg);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_prod <= w_gain * r3_car;
            r4_car  <= r3_car;
            r4_msg  <= r3_msg;
            r4_last <= r3_last;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_carrier   <= r4_car;
            o_message   <= r4_msg;
            o_modulated <= f_sat18(40'((r4_prod + 36'sd16384) >>> 15));
            o_last      <= r4_last;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r4_v        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r1_v        <= i_q_valid;
            r2_v        <= r1_v;
            r3_v        <= r2_v;
            r4_v        <= r3_v;
            r_out_valid <= r4_v;
        end
    end

    // message stays within 0.6 of full scale
    a_msg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_v |-> ($signed(r3_msg) <= MSG_LIMIT && $signed(r3_msg) >= -MSG_LIMIT))
        else $error("message sample out of range");

    // a stalled output holds its beat
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(o_modulated) && $stable(o_last)))
        else $error("output beat changed while stalled");

endmodule

/* hw/rtl/am_tone_modulator_top.sv */
// am tone modulator: one am sample per tick beat from two phase accumulators
// path: job queue, table read, gain, rounding, modulation product, output register
// one sample per cycle unless the output stalls, set by the two read ports of the sine table
// a 4-entry queue lets the front run ahead while the output is stalled
// reset is synchronous active low: phases, run index and valids clear, registers take defaults
module am_tone_modulator_top import amtm_pkg::*; #(
    parameter int PHASE_BITS = PHASE_BITS_DEF,
    parameter int TABLE_BITS = TABLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    amtm_tick_if.sink             i_tick,
    amtm_sample_if.source         o_sample,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int QW = 2 * (TABLE_BITS + 2) + 1;

    logic [PHASE_BITS-1:0] r_cstep;
    logic [PHASE_BITS-1:0] r_mstep;
    logic [AMP_W-1:0]      r_amp;
    logic [COUNT_W-1:0]    r_count;

    logic [PHASE_BITS-1:0] w_cstep;
    logic [STEP_W-1:0]     w_cstep32;
    logic [64:0]           w_div_prod;
    logic [PHASE_BITS-1:0] w_mstep;

    logic          w_push;
    logic [QW-1:0] w_job;
    logic          w_full;
    logic          w_pop;
    logic          w_q_valid;
    logic [QW-1:0] w_q_data;

    // message step: carrier step over 7 by reciprocal multiply
    assign w_cstep    = PHASE_BITS'(i_cfg_wdata[STEP_W-1:0]);
    assign w_cstep32  = STEP_W'(w_cstep);
    assign w_div_prod = 65'(w_cstep32) * 65'(DIV7_MAGIC);
    assign w_mstep    = PHASE_BITS'(w_div_prod[64:DIV7_SHIFT]);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cstep <= '0;
            r_mstep <= '0;
            r_amp   <= AMP_RESET;
            r_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CARRIER_STEP: begin
                    r_cstep <= w_cstep;
                    r_mstep <= w_mstep;
                end
                CFG_AMPLITUDE: begin
                    r_amp <= i_cfg_wdata[AMP_W-1:0];
                end
                CFG_SAMPLE_COUNT: begin
                    r_count <= i_cfg_wdata[COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // front end
    amtm_front #(
        .PHASE_BITS (PHASE_BITS),
        .TABLE_BITS (TABLE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_tick.valid),
        .i_restart      (i_tick.restart),
        .o_ready        (i_tick.ready),
        .i_cstep        (r_cstep),
        .i_mstep        (r_mstep),
        .i_sample_count (r_count),
        .o_push         (w_push),
        .o_job          (w_job),
        .i_full         (w_full)
    );

    // job queue
    amtm_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    // back end
    amtm_back #(
        .TABLE_BITS (TABLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_data),
        .o_pop       (w_pop),
        .i_amplitude (r_amp),
        .o_valid     (o_sample.valid),
        .i_ready     (o_sample.ready),
        .o_carrier   (o_sample.carrier_sample),
        .o_message   (o_sample.message_sample),
        .o_modulated (o_sample.modulated_sample),
        .o_last      (o_sample.last)
    );

endmodule

/* tb/tb_top.sv */
// self-checking testbench of the am tone modulator: directed table, random phases, stalls
`timescale 1ns / 1ps

module tb_top;
    import amtm_pkg::*;

    localparam int QUARTER_SHIFT = PHASE_BITS_DEF - TABLE_BITS_DEF - 2;
    localparam int TBL_LAST      = (1 << TABLE_BITS_DEF) - 1;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 60;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 120;
    localparam int HOLD_PHASE    = 3;
    localparam int MSG_DIVIDER   = 7;
    localparam int REPORT_LIMIT  = 10;

    localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
    localparam logic [STEP_W-1:0] QUARTER_TURN = 32'h4000_0000;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] carrier;
        logic signed [MSG_W-1:0]    message;
        logic signed [SAMPLE_W-1:0] modulated;
        logic                       last;
    } t_am_sample;

    typedef enum logic {ROW_TICK, ROW_CFG} t_row_kind;

    // one directed step: a register write or a tick, with optional known result
    typedef struct packed {
        t_row_kind                  kind;
        logic [CFG_IDX_W-1:0]       idx;
        logic [CFG_DATA_W-1:0]      data;
        logic                       restart;
        logic                       typed;
        logic signed [SAMPLE_W-1:0] carrier;
        logic signed [SAMPLE_W-1:0] modulated;
        logic                       last;
    } t_dir_row;

    localparam int DIR_ROWS = 34;
    localparam t_dir_row DIR_TBL [DIR_ROWS] = '{
        // defaults straight after reset
        '{ROW_TICK, CFG_SPARE,        32'd0,          1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_TICK, CFG_SPARE,        32'd0,          1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_TICK, CFG_SPARE,        32'd0,          1'b1, 1'b0, 18'sd0, 18'sd0, 1'b0},
        // zero amplitude silences carrier and output
        '{ROW_CFG,  CFG_AMPLITUDE,    32'd0,          1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_TICK, CFG_SPARE,        32'd0,          1'b1, 1'b1, 18'sd0, 18'sd0, 1'b0},
        '{ROW_TICK, CFG_SPARE,        32'd0,          1'b0, 1'b1, 18'sd0, 18'sd0, 1'b0},
        // one-sample runs flag every sample
        '{ROW_CFG,  CFG_SAMPLE_COUNT, 32'd1,          1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_TICK, CFG_SPARE,        32'd0,          1'b1, 1'b1, 18'sd0, 18'sd0, 1'b1},
        '{ROW_TICK, CFG_SPARE,        32'd0,          1'b0, 1'b1, 18'sd0, 18'sd0, 1'b1},
        // full amplitude, quarter-turn step, run of four then wrap
        '{ROW_CFG,  CFG_AMPLITUDE,    32'd65535,      1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_CFG,  CFG_CARRIER_STEP, 32'h4000_0000,  1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_CFG,  CFG_SAMPLE_COUNT, 32'd4,          1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_TICK, CFG_SPARE,        32'd0,          1'b1, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_TICK, CFG_SPARE,        32'd0,          1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_TICK, CFG_SPARE,        32'd0,          1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_TICK, CFG_SPARE,        32'd0,          1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_TICK, CFG_SPARE,        32'd0,          1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        // largest step, restart on the first sample of a run
        '{ROW_CFG,  CFG_CARRIER_STEP, 32'hFFFF_FFFF,  1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_CFG,  CFG_SAMPLE_COUNT, 32'd3,          1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_TICK, CFG_SPARE,        32'd0,          1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_TICK, CFG_SPARE,        32'd0,          1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_TICK, CFG_SPARE,        32'd0,          1'b1, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_TICK, CFG_SPARE,        32'd0,          1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        // zero count runs the full index range, spare index is ignored
        '{ROW_CFG,  CFG_SAMPLE_COUNT, 32'd0,          1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_CFG,  CFG_SPARE,        32'hDEAD_BEEF,  1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_TICK, CFG_SPARE,        32'd0,          1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        // upper data bits beyond the register width are dropped
        '{ROW_CFG,  CFG_AMPLITUDE,    32'hABCD_9000,  1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_CFG,  CFG_SAMPLE_COUNT, 32'hFF00_0002,  1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_TICK, CFG_SPARE,        32'd0,          1'b1, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_TICK, CFG_SPARE,        32'd0,          1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_TICK, CFG_SPARE,        32'd0,          1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        // half-turn step
        '{ROW_CFG,  CFG_CARRIER_STEP, 32'h8000_0000,  1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_TICK, CFG_SPARE,        32'd0,          1'b1, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{ROW_TICK, CFG_SPARE,        32'd0,          1'b0, 1'b0, 18'sd0, 18'sd0, 1'b0}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    amtm_tick_if   tick_ch ();
    amtm_sample_if sample_ch ();

    am_tone_modulator_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (tick_ch),
        .o_sample    (sample_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // predictor copy of registers and accumulators
    logic [ENTRY_W-1:0] quarter_sine [1 << TABLE_BITS_DEF];
    logic [STEP_W-1:0]  step_reg;
    logic [AMP_W-1:0]   amp_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [STEP_W-1:0]  car_phase;
    logic [STEP_W-1:0]  msg_phase;
    logic [COUNT_W-1:0] run_idx;

    t_am_sample pending_samples [$];

    int  err_cnt         = 0;
    int  samples_checked = 0;
    int  last_cnt        = 0;
    int  restart_cnt     = 0;
    int  reg_writes      = 0;
    int  burst_left      = 0;
    logic hold_req       = 1'b0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // signed sine of a phase from the quarter-wave table
    function automatic int sine_at(input logic [STEP_W-1:0] ph);
        logic [TABLE_BITS_DEF+1:0] a;
        int v;
        a = (TABLE_BITS_DEF + 2)'(ph >> QUARTER_SHIFT);
        v = a[TABLE_BITS_DEF] ? int'(quarter_sine[TBL_LAST - a[TABLE_BITS_DEF-1:0]])
                              : int'(quarter_sine[a[TABLE_BITS_DEF-1:0]]);
        return a[TABLE_BITS_DEF+1] ? -v : v;
    endfunction

    // drop 15 fraction bits, rounding half up
    function automatic longint round15(input longint p);
        return (p + 64'sd16384) >>> 15;
    endfunction

    function automatic longint sat18(input longint v);
        if (v > longint'(SAT_MAX)) begin
            return longint'(SAT_MAX);
        end else if (v < longint'(SAT_MIN)) begin
            return longint'(SAT_MIN);
        end
        return v;
    endfunction

    // next am sample, advancing the accumulators and run index
    function automatic t_am_sample predict_am_sample(input logic rbit);
        t_am_sample s;
        longint car;
        longint msg;
        longint mod;
        logic end_of_run;
        if (rbit) begin
            car_phase = '0;
            msg_phase = '0;
            run_idx   = '0;
        end
        car = sat18(round15(longint'(amp_reg) * longint'(sine_at(car_phase))));
        msg = round15(longint'(MSG_GAIN) * longint'(sine_at(msg_phase + QUARTER_TURN)));
        mod = sat18(round15((longint'(ONE_Q15) + msg) * car));
        end_of_run = (COUNT_W'(run_idx + 1'b1) == count_reg);
        s.carrier   = car[SAMPLE_W-1:0];
        s.message   = msg[MSG_W-1:0];
        s.modulated = mod[SAMPLE_W-1:0];
        s.last      = end_of_run;
        if (end_of_run) begin
            car_phase = '0;
            msg_phase = '0;
            run_idx   = '0;
        end else begin
            car_phase = car_phase + step_reg;
            msg_phase = msg_phase + step_reg / MSG_DIVIDER;
            run_idx   = run_idx + 1'b1;
        end
        return s;
    endfunction

    // offer one tick beat, bursts with random gaps, predict on acceptance
    task automatic send_tick(input logic rbit, input logic typed, input t_am_sample known);
        t_am_sample want;
        int gap;
        if (burst_left == 0) begin
            gap = (hold_req || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                tick_ch.valid   <= 1'b0;
                tick_ch.restart <= 1'($urandom);
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge i_clk);
        tick_ch.valid   <= 1'b1;
        tick_ch.restart <= rbit;
        @(posedge i_clk);
        while (!tick_ch.ready) @(posedge i_clk);
        want = predict_am_sample(rbit);
        if (typed) begin
            want.carrier   = known.carrier;
            want.modulated = known.modulated;
            want.last      = known.last;
        end
        pending_samples.push_back(want);
        if (rbit) restart_cnt++;
        burst_left--;
    endtask

    // stop offering and wait for every outstanding sample plus pipeline slack
    task automatic drain_pipeline();
        @(negedge i_clk);
        tick_ch.valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_CARRIER_STEP: step_reg  = data[STEP_W-1:0];
            CFG_AMPLITUDE:    amp_reg   = data[AMP_W-1:0];
            CFG_SAMPLE_COUNT: count_reg = data[COUNT_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // sample sink: ready pattern changes mode now and then, plus one long hold
    initial begin
        int mode_left;
        int mode;
        logic toggle;
        mode_left = 0;
        mode      = 0;
        toggle    = 1'b0;
        sample_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                sample_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                toggle = ~toggle;
                case (mode)
                    0:       sample_ch.ready <= 1'b1;
                    1:       sample_ch.ready <= ($urandom_range(0, 2) != 0);
                    2:       sample_ch.ready <= toggle;
                    default: sample_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // compare each sample beat with the oldest expected one
    always @(posedge i_clk) begin
        t_am_sample got;
        t_am_sample want;
        if (i_rst_n && sample_ch.valid && sample_ch.ready) begin
            got.carrier   = sample_ch.carrier_sample;
            got.message   = sample_ch.message_sample;
            got.modulated = sample_ch.modulated_sample;
            got.last      = sample_ch.last;
            if (pending_samples.size() == 0) begin
                if (err_cnt < REPORT_LIMIT)
                    $display("unexpected sample beat: carrier %0d message %0d modulated %0d",
                             got.carrier, got.message, got.modulated);
                err_cnt++;
            end else begin
                want = pending_samples.pop_front();
                if (got !== want) begin
                    if (err_cnt < REPORT_LIMIT) begin
                        $display("sample %0d mismatch: expected car %0d msg %0d mod %0d last %0b",
                                 samples_checked, want.carrier, want.message, want.modulated,
                                 want.last);
                        $display("                     got      car %0d msg %0d mod %0d last %0b",
                                 got.carrier, got.message, got.modulated, got.last);
                    end
                    err_cnt++;
                end
                samples_checked++;
                if (got.last) last_cnt++;
            end
        end
    end

    // stimulus
    initial begin
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned acc;
        t_am_sample known;
        logic rbit;
        logic [STEP_W-1:0]  step_pick;
        logic [AMP_W-1:0]   amp_pick;
        logic [COUNT_W-1:0] cnt_pick;

        // quarter-wave table: taylor series of sin in q30, scaled to unsigned q0.15
        for (int k = 0; k <= TBL_LAST; k++) begin
            x    = (HALF_PI_Q30 * longint'(2 * k + 1)) >> (TABLE_BITS_DEF + 1);
            x2   = (x * x) >> 30;
            term = x;
            acc  = x;
            for (int n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = (acc >= term) ? acc - term : 64'd0;
                end else begin
                    acc = acc + term;
                end
            end
            quarter_sine[k] = ENTRY_W'((acc * 64'd32767 + (64'd1 << 29)) >> 30);
        end

        step_reg  = '0;
        amp_reg   = AMP_RESET;
        count_reg = COUNT_RESET;
        car_phase = '0;
        msg_phase = '0;
        run_idx   = '0;

        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_CARRIER_STEP;
        cfg_wdata       = '0;
        tick_ch.valid   = 1'b0;
        tick_ch.restart = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIR_TBL[r].kind == ROW_CFG) begin
                drain_pipeline();
                write_reg(DIR_TBL[r].idx, DIR_TBL[r].data);
            end else begin
                known.carrier   = DIR_TBL[r].carrier;
                known.message   = '0;
                known.modulated = DIR_TBL[r].modulated;
                known.last      = DIR_TBL[r].last;
                send_tick(DIR_TBL[r].restart, DIR_TBL[r].typed, known);
            end
        end

        // random phases, each with its own register setting
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin
                    step_pick = '1;
                    amp_pick  = '1;
                    cnt_pick  = COUNT_W'(1);
                end
                1: begin
                    step_pick = '0;
                    amp_pick  = '0;
                    cnt_pick  = COUNT_RESET;
                end
                2: begin
                    step_pick = STEP_W'(1);
                    amp_pick  = AMP_RESET;
                    cnt_pick  = '1;
                end
                default: begin
                    step_pick = $urandom;
                    amp_pick  = $urandom_range(0, 65535);
                    cnt_pick  = ($urandom_range(0, 3) == 0) ? COUNT_RESET
                                                            : COUNT_W'($urandom_range(1, 48));
                end
            endcase
            drain_pipeline();
            write_reg(CFG_CARRIER_STEP, step_pick);
            write_reg(CFG_AMPLITUDE, {16'($urandom), amp_pick});
            write_reg(CFG_SAMPLE_COUNT, {8'($urandom), cnt_pick});
            if (ph % 2 == 1) write_reg(CFG_SPARE, $urandom);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // output held off while ticks keep coming
                if (ph == HOLD_PHASE && i == 40) hold_req = 1'b1;
                rbit = ($urandom_range(0, 15) == 0);
                send_tick(rbit, 1'b0, '0);
            end
        end

        drain_pipeline();

        $display("run covered %0d samples, %0d end-of-run flags, %0d restarts",
                 samples_checked, last_cnt, restart_cnt);
        $display("%0d register writes over %0d random settings, one %0d-cycle output hold",
                 reg_writes, RAND_PHASES, LONG_HOLD);
        if (err_cnt == 0 && pending_samples.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
